@@ rtl/ctb_pkg.sv @@
package ctb_pkg;

	localparam int unsigned ID_W    = 29;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned BADDR_W = 17;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned START_W = 14;
	localparam int unsigned SIZE_W  = 3;
	localparam int unsigned WADDR_W = BADDR_W - 2;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = START_W;

	localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;
	localparam logic [CNT_W-1:0] HEADER_WORDS = 5'd2;
	localparam int unsigned XTD_BIT = 30;
	localparam int unsigned LEN_SHIFT = 16;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 1'd1;

	// Result select codes from controller to datapath.
	localparam int unsigned SEL_W = 3;
	localparam logic [SEL_W-1:0] SEL_T0     = 3'd0;
	localparam logic [SEL_W-1:0] SEL_T1     = 3'd1;
	localparam logic [SEL_W-1:0] SEL_DATA   = 3'd2;
	localparam logic [SEL_W-1:0] SEL_REQ    = 3'd3;
	localparam logic [SEL_W-1:0] SEL_REJ    = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]   frame_id;
		logic [LEN_W-1:0]  length_code;
		logic [DATA_W-1:0] payload;
		logic              queue_full;
		logic [IDX_W-1:0]  put_index;
	} frame_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BADDR_W-1:0] byte_address;
		logic [WORD_W-1:0]  word;
		logic               last;
	} result_t;

	typedef struct packed {
		logic             load;
		logic             emit;
		logic [SEL_W-1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic last_data;
	} sts_t;

	// Number of data words in an element for each size code.
	function automatic logic [CNT_W-1:0] data_words(input logic [SIZE_W-1:0] code);
		logic [CNT_W-1:0] n;
		begin
			case (code)
				3'd0: n = 5'd2;
				3'd1: n = 5'd3;
				3'd2: n = 5'd4;
				3'd3: n = 5'd5;
				3'd4: n = 5'd6;
				3'd5: n = 5'd8;
				3'd6: n = 5'd12;
				default: n = 5'd16;
			endcase
			return n;
		end
	endfunction

endpackage

@@ rtl/ctb_frame_if.sv @@
interface ctb_frame_if;
	logic              valid;
	logic              ready;
	ctb_pkg::frame_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ctb_result_if.sv @@
interface ctb_result_if;
	logic              valid;
	logic              ready;
	ctb_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ctb_dp.sv @@
module ctb_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ctb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ctb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  ctb_pkg::frame_t                     frame,
	input  ctb_pkg::cmd_t                       cmd,
	output ctb_pkg::sts_t                       sts,
	output ctb_pkg::result_t                    result
);

	logic [ctb_pkg::START_W-1:0] start_q;
	logic [ctb_pkg::SIZE_W-1:0]  size_code_q;

	logic [ctb_pkg::ID_W-1:0]    id_q;
	logic [ctb_pkg::LEN_W-1:0]   len_q;
	logic [ctb_pkg::LEN_W-1:0]   rem_q;
	logic [ctb_pkg::WORD_W-1:0]  t1_word;
	logic [ctb_pkg::DATA_W-1:0]  data_q;
	logic [ctb_pkg::IDX_W-1:0]   idx_q;
	logic [ctb_pkg::WADDR_W-1:0] addr_q;
	logic [ctb_pkg::CNT_W-1:0]   words_left_q;
	ctb_pkg::result_t            result_q;

	logic [ctb_pkg::CNT_W-1:0]   stride;
	logic [ctb_pkg::WADDR_W-1:0] base;
	logic [ctb_pkg::LEN_W-1:0]   len_sat;
	logic [ctb_pkg::WORD_W-1:0]  data_word;
	ctb_pkg::result_t            next_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			size_code_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctb_pkg::CFG_BUFFER_START: start_q <= cfg_data;
				ctb_pkg::CFG_ELEMENT_SIZE: size_code_q <= cfg_data[ctb_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign stride  = ctb_pkg::HEADER_WORDS + ctb_pkg::data_words(size_code_q);
	assign base    = ctb_pkg::WADDR_W'(start_q) +
		ctb_pkg::WADDR_W'(frame.put_index * stride);
	assign len_sat = (frame.length_code > ctb_pkg::MAX_LEN) ? ctb_pkg::MAX_LEN
		: frame.length_code;

	// Bytes past the frame length read as zero; rem_q counts the bytes left.
	always_comb begin
		data_word = '0;
		for (int b = 0; b < 4; b++) begin
			if (ctb_pkg::LEN_W'(b) < rem_q) begin
				data_word[8*b +: 8] = data_q[8*b +: 8];
			end
		end
	end

	always_comb begin
		t1_word = '0;
		t1_word[ctb_pkg::LEN_SHIFT +: ctb_pkg::LEN_W] = len_q;
	end

	always_comb begin
		next_result = '0;
		case (cmd.sel)
			ctb_pkg::SEL_T0: begin
				next_result.kind         = ctb_pkg::KIND_WRITE;
				next_result.byte_address = {addr_q, 2'b00};
				next_result.word         = {1'b0, 1'b1, 1'b0, id_q};
			end
			ctb_pkg::SEL_T1: begin
				next_result.kind         = ctb_pkg::KIND_WRITE;
				next_result.byte_address = {addr_q, 2'b00};
				next_result.word         = t1_word;
			end
			ctb_pkg::SEL_DATA: begin
				next_result.kind         = ctb_pkg::KIND_WRITE;
				next_result.byte_address = {addr_q, 2'b00};
				next_result.word         = data_word;
			end
			ctb_pkg::SEL_REQ: begin
				next_result.kind         = ctb_pkg::KIND_REQUEST;
				next_result.word         = ctb_pkg::WORD_W'(1) << idx_q;
				next_result.last         = 1'b1;
			end
			default: begin
				next_result.kind = ctb_pkg::KIND_REJECT;
				next_result.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q         <= frame.frame_id;
			len_q        <= len_sat;
			rem_q        <= len_sat;
			data_q       <= frame.payload;
			idx_q        <= frame.put_index;
			addr_q       <= base;
			words_left_q <= ctb_pkg::data_words(size_code_q);
		end else if (cmd.emit) begin
			if (cmd.sel == ctb_pkg::SEL_T0 || cmd.sel == ctb_pkg::SEL_T1) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.sel == ctb_pkg::SEL_DATA) begin
				addr_q       <= addr_q + 1'b1;
				data_q       <= data_q >> 32;
				rem_q        <= (rem_q > 4'd4) ? rem_q - 4'd4 : '0;
				words_left_q <= words_left_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			result_q <= next_result;
		end
	end

	assign sts.last_data = (words_left_q == ctb_pkg::CNT_W'(1));
	assign result        = result_q;

endmodule

@@ rtl/ctb_ctrl.sv @@
module ctb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_full,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ctb_pkg::sts_t  sts,
	output ctb_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_T0   = 3'd1;
	localparam logic [2:0] S_T1   = 3'd2;
	localparam logic [2:0] S_DATA = 3'd3;
	localparam logic [2:0] S_REQ  = 3'd4;
	localparam logic [2:0] S_REJ  = 3'd5;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       accept;
	logic       emit;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// A new result may enter the output register when it is empty or draining.
	assign emit     = (state_q != S_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.load = accept;
		cmd.emit = emit;
		unique case (state_q)
			S_T0:    cmd.sel = ctb_pkg::SEL_T0;
			S_T1:    cmd.sel = ctb_pkg::SEL_T1;
			S_DATA:  cmd.sel = ctb_pkg::SEL_DATA;
			S_REQ:   cmd.sel = ctb_pkg::SEL_REQ;
			default: cmd.sel = ctb_pkg::SEL_REJ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= in_full ? S_REJ : S_T0;
				S_T0:   if (emit) state_q <= S_T1;
				S_T1:   if (emit) state_q <= S_DATA;
				S_DATA: if (emit && sts.last_data) state_q <= S_REQ;
				S_REQ:  if (emit) state_q <= S_IDLE;
				S_REJ:  if (emit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cmd.emit)
		else $error("emit while idle");

	a_full_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_full |=> state_q == S_REJ)
		else $error("full queue did not lead to rejection");

	a_req_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REQ && emit |=> state_q == S_IDLE)
		else $error("request did not end the frame");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

@@ rtl/can_tx_element_builder.sv @@
// Channel     Dir  Transaction
// frame_in    in   one CAN frame: id, length, payload, queue_full, put_index
// result_out  out  one element word write, transmit request or rejection
// cfg_*       in   register write, index 0 buffer start, index 1 size code
//
// A frame is taken only while no frame is in work, then gives one result per
// cycle from the sequencer while result_out takes them: T0, T1, data words
// (2..16), request (up to 19 results); a full queue gives a rejection.
// Back-pressure on result_out holds the sequencer; results sit in one
// output register. Reset clears the state, the output valid flag and both configuration registers.
module can_tx_element_builder (
	input  logic                           clk,
	input  logic                           arst_n,
	ctb_frame_if.sink                      frame_in,
	ctb_result_if.source                   result_out,
	input  logic                           cfg_we,
	input  logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctb_pkg::CFG_DATA_W-1:0] cfg_data
);

	ctb_pkg::cmd_t cmd;
	ctb_pkg::sts_t sts;

	ctb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame_in.valid),
		.in_full   (frame_in.data.queue_full),
		.in_ready  (frame_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame_in.data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result_out.data)
	);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		ctb_pkg::frame_t f;
		bit              drain_first;
	} queued_frame_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ctb_pkg::CFG_DATA_W-1:0] cfg_data;

	ctb_frame_if  frame_ch();
	ctb_result_if result_ch();

	can_tx_element_builder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_ch),
		.result_out (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	queued_frame_t    pending_frames[$];
	ctb_pkg::result_t expected_results[$];

	logic [ctb_pkg::START_W-1:0] cur_start;
	logic [ctb_pkg::SIZE_W-1:0]  cur_size;

	int  frames_taken;
	int  errors;
	int  cycle_count;
	int  hold_left;
	bit  hold_done;
	logic steady;

	// Both sides stop idling for a while somewhere in the middle of the run.
	assign steady = (frames_taken >= 120) && (frames_taken < 170);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int element_data_words(input logic [ctb_pkg::SIZE_W-1:0] code);
		int nbytes;
		case (code)
			3'd0: nbytes = 8;
			3'd1: nbytes = 12;
			3'd2: nbytes = 16;
			3'd3: nbytes = 20;
			3'd4: nbytes = 24;
			3'd5: nbytes = 32;
			3'd6: nbytes = 48;
			default: nbytes = 64;
		endcase
		return nbytes / 4;
	endfunction

	// Lays out the expected transmit element for one accepted frame.
	task automatic queue_element_writes(input ctb_pkg::frame_t f);
		ctb_pkg::result_t r;
		int len;
		int ndw;
		int base;
		int pos;
		logic [ctb_pkg::WORD_W-1:0] w;
		if (f.queue_full) begin
			r.kind = ctb_pkg::KIND_REJECT;
			r.byte_address = '0;
			r.word = '0;
			r.last = 1'b1;
			expected_results.push_back(r);
		end else begin
			len = (f.length_code > ctb_pkg::MAX_LEN) ? int'(ctb_pkg::MAX_LEN)
				: int'(f.length_code);
			ndw = element_data_words(cur_size);
			base = int'(cur_start)
				+ int'(f.put_index) * (int'(ctb_pkg::HEADER_WORDS) + ndw);
			r.kind = ctb_pkg::KIND_WRITE;
			r.last = 1'b0;
			r.byte_address = ctb_pkg::BADDR_W'(base * 4);
			r.word = (32'd1 << ctb_pkg::XTD_BIT) | ctb_pkg::WORD_W'(f.frame_id);
			expected_results.push_back(r);
			r.byte_address = ctb_pkg::BADDR_W'((base + 1) * 4);
			r.word = ctb_pkg::WORD_W'(len) << ctb_pkg::LEN_SHIFT;
			expected_results.push_back(r);
			for (int k = 0; k < ndw; k++) begin
				w = '0;
				for (int b = 0; b < 4; b++) begin
					pos = k * 4 + b;
					if (pos < len)
						w[8*b +: 8] = f.payload[8*pos +: 8];
				end
				r.byte_address =
					ctb_pkg::BADDR_W'((base + int'(ctb_pkg::HEADER_WORDS) + k) * 4);
				r.word = w;
				expected_results.push_back(r);
			end
			r.kind = ctb_pkg::KIND_REQUEST;
			r.byte_address = '0;
			r.word = 32'd1 << f.put_index;
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	// Frame driver.
	always @(posedge clk) begin
		queued_frame_t nxt;
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
		end else if (!frame_ch.valid || frame_ch.ready) begin
			if (frame_ch.valid) begin
				queue_element_writes(frame_ch.data);
				frames_taken++;
			end
			if (pending_frames.size() != 0
					&& !(pending_frames[0].drain_first && expected_results.size() != 0)
					&& (steady || $urandom_range(0, 99) >= 19)) begin
				nxt = pending_frames.pop_front();
				frame_ch.valid <= 1'b1;
				frame_ch.data <= nxt.f;
			end else begin
				frame_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		ctb_pkg::result_t got;
		ctb_pkg::result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result kind %0d addr %h word %h last %b",
						$time, got.kind, got.byte_address, got.word, got.last);
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.byte_address !== want.byte_address
							|| got.word !== want.word || got.last !== want.last) begin
						errors++;
						$display({"%0t: expected kind %0d addr %h word %h last %b,",
							" got kind %0d addr %h word %h last %b"},
							$time, want.kind, want.byte_address, want.word, want.last,
							got.kind, got.byte_address, got.word, got.last);
					end
				end
			end
			// One long hold-off while frames keep coming, so the input backs up.
			if (!hold_done && frames_taken >= 50) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	task automatic write_reg(input logic [ctb_pkg::CFG_IDX_W-1:0] idx,
			input logic [ctb_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ctb_pkg::CFG_BUFFER_START)
			cur_start = val;
		else
			cur_size = val[ctb_pkg::SIZE_W-1:0];
	endtask

	task automatic add_frame(input logic [ctb_pkg::ID_W-1:0] id,
			input logic [ctb_pkg::LEN_W-1:0] len,
			input logic [ctb_pkg::DATA_W-1:0] payload, input logic full,
			input logic [ctb_pkg::IDX_W-1:0] idx);
		queued_frame_t q;
		q.f.frame_id = id;
		q.f.length_code = len;
		q.f.payload = payload;
		q.f.queue_full = full;
		q.f.put_index = idx;
		q.drain_first = 1'b0;
		pending_frames.push_back(q);
	endtask

	function automatic queued_frame_t random_frame();
		queued_frame_t q;
		q.f.frame_id = ctb_pkg::ID_W'($urandom);
		q.f.length_code = ($urandom_range(0, 99) < 15)
			? ctb_pkg::LEN_W'($urandom_range(9, 15))
			: ctb_pkg::LEN_W'($urandom_range(0, 8));
		q.f.payload = {$urandom, $urandom};
		q.f.queue_full = ($urandom_range(0, 9) == 0);
		q.f.put_index = ctb_pkg::IDX_W'($urandom_range(0, 31));
		q.drain_first = 1'b0;
		return q;
	endfunction

	// Waits until every queued frame has gone in and every result has come out.
	task automatic settle();
		do
			@(posedge clk);
		while (pending_frames.size() != 0 || frame_ch.valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		queued_frame_t q;
		logic [ctb_pkg::START_W-1:0] start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data = '0;
		result_ch.ready = 1'b0;
		cur_start = '0;
		cur_size = '0;
		frames_taken = 0;
		errors = 0;
		cycle_count = 0;
		hold_left = 0;
		hold_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset settings.
		add_frame('0, 4'd0, '0, 1'b0, 5'd0);
		add_frame('1, 4'd15, '1, 1'b0, 5'd31);
		add_frame(29'h0ABCDEF1, 4'd8, {$urandom, $urandom}, 1'b0, 5'd7);
		add_frame(29'h15555555, 4'd9, {$urandom, $urandom}, 1'b0, 5'd12);
		for (int n = 1; n < 8; n++)
			add_frame(ctb_pkg::ID_W'($urandom), ctb_pkg::LEN_W'(n),
				64'h0807060504030201 ^ {$urandom, $urandom},
				1'b0, ctb_pkg::IDX_W'($urandom_range(0, 31)));
		add_frame('1, 4'd15, '1, 1'b1, 5'd31);
		add_frame('0, 4'd0, '0, 1'b1, 5'd0);
		settle();

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: start = '1;
				1: start = '0;
				default: start = ctb_pkg::START_W'($urandom_range(0, 16383));
			endcase
			write_reg(ctb_pkg::CFG_BUFFER_START, start);
			write_reg(ctb_pkg::CFG_ELEMENT_SIZE,
				(ctb_pkg::CFG_DATA_W'($urandom) & 14'h3FF8)
				| ctb_pkg::CFG_DATA_W'((p + 7) % 8));
			if (p == 0) begin
				// Largest element at the highest start and index.
				add_frame('1, 4'd8, '1, 1'b0, 5'd31);
				add_frame(29'h0AAAAAAA, 4'd3, {$urandom, $urandom}, 1'b0, 5'd0);
				add_frame(29'h15555555, 4'd12, {$urandom, $urandom}, 1'b0, 5'd30);
				add_frame('1, 4'd5, '1, 1'b1, 5'd31);
			end
			for (int n = 0; n < 27; n++) begin
				q = random_frame();
				// Once, the sender holds back until the block has fully drained.
				q.drain_first = (p == 4) && (n == 12);
				pending_frames.push_back(q);
			end
			settle();
		end

		repeat (30) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
